@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that are compiled in for simulation only.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BPRA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BPRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPRA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BPRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/bpra_pkg.sv @@
// ----------------------------------------------------------------------------
// bpra_pkg
// Types and constants shared by the page run allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpra_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int CNT_W     = 11;
    localparam int ADDR_W    = 32;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic REG_BASE_ADDRESS = 1'b0;

    typedef enum logic
    {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        STATUS_OK      = 2'd0,
        STATUS_NOSPACE = 2'd1,
        STATUS_BAD     = 2'd2
    } status_t;

    typedef enum logic [3:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_FREE_CHK,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_RESP
    } state_t;

    typedef struct packed
    {
        logic    clr_step;
        logic    req_load;
        logic    scan_start;
        logic    scan_step;
        logic    off_load;
        logic    free_setup;
        logic    mark_rd;
        logic    mark_wr;
        logic    out_load;
        status_t out_code;
    } dp_cmd_t;

    typedef struct packed
    {
        logic clr_last;
        logic bad_count;
        logic is_free;
        logic hit;
        logic scan_last;
        logic free_bad;
        logic mark_last;
    } dp_sts_t;

endpackage

@@ rtl/core/bpra_req_if.sv @@
// ----------------------------------------------------------------------------
// bpra_req_if
// Request channel: allocate or free a run of pages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bpra_req_if;

    logic                          valid;
    logic                          ready;
    bpra_pkg::action_t             action;
    logic [bpra_pkg::CNT_W-1:0]    page_count;
    logic [bpra_pkg::ADDR_W-1:0]   address;

    modport source
    (
        output valid,
        output action,
        output page_count,
        output address,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  action,
        input  page_count,
        input  address,
        output ready
    );

endinterface

@@ rtl/core/bpra_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bpra_rsp_if
// Response channel: run address and completion status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bpra_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [bpra_pkg::ADDR_W-1:0]   address_res;
    bpra_pkg::status_t             status;

    modport source
    (
        output valid,
        output address_res,
        output status,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  address_res,
        input  status,
        output ready
    );

endinterface

@@ rtl/core/bpra_datapath.sv @@
// ----------------------------------------------------------------------------
// bpra_datapath
// Page bitmap memory, word-wide run search, page offset split by shift and
// mask (PAGE_BYTES is a power of two), run marking, and the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpra_datapath #(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpra_pkg::dp_cmd_t             cmd,
    output bpra_pkg::dp_sts_t             sts,
    input  logic [bpra_pkg::ADDR_W-1:0]   base_address,
    input  bpra_pkg::action_t             req_action,
    input  logic [bpra_pkg::CNT_W-1:0]    req_page_count,
    input  logic [bpra_pkg::ADDR_W-1:0]   req_address,
    output logic [bpra_pkg::ADDR_W-1:0]   address_res,
    output bpra_pkg::status_t             status
);

    import bpra_pkg::*;

    localparam int WORDS     = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW        = AW + BIT_W;
    localparam int SW        = ((PW > CNT_W) ? PW : CNT_W) + 1;
    localparam int LAST_BITS = NUM_PAGES - (WORDS - 1) * WORD_BITS;
    localparam int RW        = $clog2(PAGE_BYTES);

    localparam logic [WORD_BITS-1:0] PAD_MASK = (LAST_BITS == WORD_BITS) ? '0 :
        ~((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));
    localparam logic [AW-1:0]     LAST_WORD   = AW'(WORDS - 1);
    localparam logic [ADDR_W-1:0] PB_MUL      = ADDR_W'(PAGE_BYTES);
    localparam logic [ADDR_W:0]   NUM_PAGES_X = (ADDR_W + 1)'(NUM_PAGES);
    localparam logic [ADDR_W-1:0] NUM_PAGES_A = ADDR_W'(NUM_PAGES);

    // request
    action_t             act_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [ADDR_W-1:0]   addr_reg;

    // bitmap memory
    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 mem_we;
    logic                 mem_re;

    // control counters
    logic [AW-1:0]     clr_reg;
    logic [AW-1:0]     k_reg;
    logic [AW-1:0]     mk_reg;
    logic [CNT_W-1:0]  run_reg;

    // run and arithmetic
    logic [PW-1:0]      s_reg;
    logic [PW-1:0]      e_reg;
    logic [ADDR_W-1:0]  prod_reg;
    logic [ADDR_W-1:0]  quo_reg;
    logic [RW-1:0]      rem_reg;
    logic [ADDR_W-1:0]  address_res_reg;
    status_t            status_reg;

    // search
    logic [WORD_BITS-1:0] used;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_W:0]       rs [BIT_W+1][WORD_BITS];
    logic [CNT_W:0]       run_end [WORD_BITS];
    logic [WORD_BITS-1:0] hit_vec;
    logic                 hit;
    logic [BIT_W-1:0]     hit_bit;
    logic [PW-1:0]        page_at;
    logic [SW-1:0]        start_wide;
    logic [PW-1:0]        start_page;
    logic [CNT_W-1:0]     run_next;

    // marking
    logic [BIT_W-1:0]     lo;
    logic [BIT_W-1:0]     hi;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] marked;

    // offset and range check
    logic [ADDR_W-1:0]    off;
    logic [ADDR_W:0]      end_x;
    logic [ADDR_W-1:0]    free_last;

    always_comb
    begin
        used      = rd_data_reg | ((k_reg == LAST_WORD) ? PAD_MASK : '0);
        free_bits = ~used;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            rs[0][j] = {BIT_W'(0), free_bits[j]};
        end
        // length of the free stretch ending at each bit, by span doubling
        for (int s = 0; s < BIT_W; s++)
        begin
            for (int j = 0; j < WORD_BITS; j++)
            begin
                rs[s+1][j] = rs[s][j];
            end
            for (int j = (1 << s); j < WORD_BITS; j++)
            begin
                if (rs[s][j] == (BIT_W + 1)'(1 << s))
                begin
                    rs[s+1][j] = rs[s][j] + rs[s][j - (1 << s)];
                end
            end
        end
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (rs[BIT_W][j] == (BIT_W + 1)'(j + 1))
            begin
                run_end[j] = {1'b0, run_reg} + (CNT_W + 1)'(j + 1);
            end
            else
            begin
                run_end[j] = (CNT_W + 1)'(rs[BIT_W][j]);
            end
            hit_vec[j] = (run_end[j] >= {1'b0, cnt_reg});
        end
        hit     = 1'b0;
        hit_bit = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (hit_vec[j])
            begin
                hit     = 1'b1;
                hit_bit = BIT_W'(j);
            end
        end
        page_at    = {k_reg, hit_bit};
        start_wide = SW'(page_at) + SW'(1) - SW'(cnt_reg);
        start_page = start_wide[PW-1:0];
        run_next   = run_end[WORD_BITS-1][CNT_W] ? '1 : run_end[WORD_BITS-1][CNT_W-1:0];
    end

    always_comb
    begin
        lo     = (mk_reg == s_reg[PW-1:BIT_W]) ? s_reg[BIT_W-1:0] : '0;
        hi     = (mk_reg == e_reg[PW-1:BIT_W]) ? e_reg[BIT_W-1:0] : '1;
        mask   = ({WORD_BITS{1'b1}} << lo) &
                 ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi));
        marked = (act_reg == ACT_ALLOC) ? (rd_data_reg | mask) : (rd_data_reg & ~mask);
    end

    always_comb
    begin
        off       = addr_reg - base_address;
        end_x     = {1'b0, quo_reg} + (ADDR_W + 1)'(cnt_reg);
        free_last = quo_reg + ADDR_W'(cnt_reg) - ADDR_W'(1);
    end

    always_comb
    begin
        if (cmd.scan_start)
        begin
            raddr = '0;
        end
        else if (cmd.scan_step)
        begin
            raddr = (k_reg == LAST_WORD) ? '0 : k_reg + AW'(1);
        end
        else
        begin
            raddr = mk_reg;
        end
        mem_re = cmd.scan_start | cmd.scan_step | cmd.mark_rd;
        mem_we = cmd.clr_step | cmd.mark_wr;
        waddr  = cmd.clr_step ? clr_reg : mk_reg;
        wdata  = cmd.clr_step ? '0 : marked;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            k_reg   <= '0;
            run_reg <= '0;
            mk_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.scan_start)
            begin
                k_reg   <= '0;
                run_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                k_reg   <= k_reg + AW'(1);
                run_reg <= run_next;
            end
            if (cmd.scan_step && hit)
            begin
                mk_reg <= start_page[PW-1:BIT_W];
            end
            else if (cmd.free_setup)
            begin
                mk_reg <= quo_reg[PW-1:BIT_W];
            end
            else if (cmd.mark_wr)
            begin
                mk_reg <= mk_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            act_reg  <= req_action;
            cnt_reg  <= req_page_count;
            addr_reg <= req_address;
        end
        if (cmd.scan_step && hit)
        begin
            s_reg <= start_page;
            e_reg <= page_at;
        end
        else if (cmd.free_setup)
        begin
            s_reg <= quo_reg[PW-1:0];
            e_reg <= free_last[PW-1:0];
        end
        if (cmd.off_load)
        begin
            quo_reg <= off >> RW;
            rem_reg <= off[RW-1:0];
        end
        prod_reg <= ADDR_W'(s_reg) * PB_MUL;
        if (cmd.out_load)
        begin
            status_reg      <= cmd.out_code;
            address_res_reg <= (cmd.out_code == STATUS_OK && act_reg == ACT_ALLOC) ?
                               base_address + prod_reg : '0;
        end
    end

    always_comb
    begin
        sts.clr_last  = (clr_reg == LAST_WORD);
        sts.bad_count = (cnt_reg == '0) || (ADDR_W'(cnt_reg) > NUM_PAGES_A);
        sts.is_free   = (act_reg == ACT_FREE);
        sts.hit       = hit;
        sts.scan_last = (k_reg == LAST_WORD);
        sts.free_bad  = (rem_reg != '0) || (end_x > NUM_PAGES_X);
        sts.mark_last = (mk_reg == e_reg[PW-1:BIT_W]);
    end

    assign address_res = address_res_reg;
    assign status      = status_reg;

endmodule

@@ rtl/core/bpra_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpra_ctrl
// Sequencer for the allocator: clear pass, search, range check, mark, respond.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpra_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bpra_pkg::dp_cmd_t    cmd,
    input  bpra_pkg::dp_sts_t    sts
);

    import bpra_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    status_t code_reg;
    status_t code_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.bad_count)
                begin
                    code_next  = STATUS_BAD;
                    state_next = ST_RESP;
                end
                else if (sts.is_free)
                begin
                    state_next = ST_FREE_CHK;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.hit)
                begin
                    state_next = ST_MARK_RD;
                end
                else if (sts.scan_last)
                begin
                    code_next  = STATUS_NOSPACE;
                    state_next = ST_RESP;
                end
            end
            ST_FREE_CHK:
            begin
                if (sts.free_bad)
                begin
                    code_next  = STATUS_BAD;
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_MARK_RD;
                end
            end
            ST_MARK_RD:
            begin
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR:
            begin
                if (sts.mark_last)
                begin
                    code_next  = STATUS_OK;
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_MARK_RD;
                end
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.out_code = code_reg;
        in_ready     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.req_load = in_valid;
            end
            ST_DECODE:
            begin
                cmd.scan_start = !sts.bad_count && !sts.is_free;
                cmd.off_load   = !sts.bad_count && sts.is_free;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_FREE_CHK:
            begin
                cmd.free_setup = !sts.free_bad;
            end
            ST_MARK_RD:
            begin
                cmd.mark_rd = 1'b1;
            end
            ST_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
            end
            ST_RESP:
            begin
                cmd.out_load = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            code_reg      <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `BPRA_ASSERT_NEXT(a_accept_decodes, clk, rst_n, in_valid && in_ready, state_reg == ST_DECODE)
    `BPRA_ASSERT_NEXT(a_hit_marks, clk, rst_n, state_reg == ST_SCAN && sts.hit, state_reg == ST_MARK_RD)
    `BPRA_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.out_load, out_valid_reg && state_reg == ST_IDLE)
    `BPRA_ASSERT_NOW(a_busy_no_take, clk, rst_n, cmd.mark_wr || cmd.scan_step, !in_ready && !cmd.out_load)

endmodule

@@ rtl/core/bitmap_page_run_allocator.sv @@
// Sequence: an allocate passes decode, a scan of the 32-page bitmap words up to the fit
//   (all words when no run fits), then a read and a write of each word the run touches;
//   a free passes decode, range check and the same marking; a bad count or bad free range
//   goes to the response from decode or range check; a result not yet taken holds the next.
// Flow: one item at a time, the next taken right after the result is loaded.
// Reset: the bitmap is swept to free, one word a cycle.
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator
// First-fit page run allocator over a bitmap, with an APB base register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_page_run_allocator #(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bpra_req_if.sink                        req,
    bpra_rsp_if.source                      rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpra_pkg::PADDR_W-1:0]    paddr,
    input  logic [bpra_pkg::PDATA_W-1:0]    pwdata,
    output logic [bpra_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    import bpra_pkg::*;

    logic [ADDR_W-1:0] base_address_reg;
    logic              cfg_wr;
    dp_cmd_t           cmd;
    dp_sts_t           sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_BASE_ADDRESS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
        end
        else if (cfg_wr)
        begin
            base_address_reg <= pwdata;
        end
    end

    assign prdata = (paddr[PADDR_W-1] == REG_BASE_ADDRESS) ? base_address_reg : '0;

    bpra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bpra_datapath #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .base_address   (base_address_reg),
        .req_action     (req.action),
        .req_page_count (req.page_count),
        .req_address    (req.address),
        .address_res    (rsp.address_res),
        .status         (rsp.status)
    );

endmodule

@@ tb/sv/tb_bitmap_page_run_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_bitmap_page_run_allocator
// Self-checking bench for the first-fit page run allocator. A directed table
// covers bad counts, full-map runs, misaligned and out-of-range frees, and
// frees of pages that are already free. Random allocate/free traffic then runs
// under several base addresses, the extremes among them, with random stalls on
// both channels and one long response hold-off. Every response is compared with the
// expected result in the table or with a bit-accurate page map kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitmap_page_run_allocator;

    import bpra_pkg::*;

    localparam int NUM_PAGES     = 1024;
    localparam int PAGE_BYTES    = 4096;
    localparam int PHASE_ITEMS   = 255;
    localparam int NUM_PHASES    = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 120;

    localparam logic [PADDR_W-1:0] BASE_ADDR_OFFSET = PADDR_W'(4 * int'(REG_BASE_ADDRESS));

    typedef struct packed
    {
        logic [ADDR_W-1:0] address_res;
        status_t           status;
    } run_result_t;

    typedef struct packed
    {
        action_t           act;
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        logic [ADDR_W-1:0] want_addr;
        status_t           want_status;
    } request_row_t;

    typedef struct
    {
        int unsigned first;
        int unsigned len;
    } live_run_t;

    localparam int NUM_ROWS = 24;

    request_row_t request_rows [NUM_ROWS] = '{
        '{ACT_ALLOC, 11'd0,    32'h0000_0000, 1'b1, 32'h0, STATUS_BAD},
        '{ACT_FREE,  11'd0,    32'h0000_0000, 1'b1, 32'h0, STATUS_BAD},
        '{ACT_ALLOC, 11'd1025, 32'h0000_0000, 1'b1, 32'h0, STATUS_BAD},
        '{ACT_ALLOC, 11'd2047, 32'hFFFF_FFFF, 1'b1, 32'h0, STATUS_BAD},
        '{ACT_ALLOC, 11'd1,    32'h0000_0000, 1'b1, 32'h0, STATUS_OK},
        '{ACT_ALLOC, 11'd1024, 32'h0000_0000, 1'b1, 32'h0, STATUS_NOSPACE},
        '{ACT_FREE,  11'd1,    32'h0000_0000, 1'b1, 32'h0, STATUS_OK},
        '{ACT_ALLOC, 11'd1024, 32'h5555_AAAA, 1'b1, 32'h0, STATUS_OK},
        '{ACT_ALLOC, 11'd1,    32'h0000_0000, 1'b1, 32'h0, STATUS_NOSPACE},
        '{ACT_FREE,  11'd1024, 32'h0000_0000, 1'b1, 32'h0, STATUS_OK},
        '{ACT_FREE,  11'd1,    32'h0000_0001, 1'b1, 32'h0, STATUS_BAD},
        '{ACT_FREE,  11'd1,    32'h0040_0000, 1'b1, 32'h0, STATUS_BAD},
        '{ACT_FREE,  11'd1,    32'h003F_F000, 1'b1, 32'h0, STATUS_OK},
        '{ACT_FREE,  11'd2,    32'h003F_F000, 1'b1, 32'h0, STATUS_BAD},
        '{ACT_FREE,  11'd1,    32'hFFFF_F000, 1'b1, 32'h0, STATUS_BAD},
        '{ACT_FREE,  11'd2047, 32'h0000_0000, 1'b1, 32'h0, STATUS_BAD},
        '{ACT_ALLOC, 11'd3,    32'h0000_0000, 1'b0, 32'h0, STATUS_OK},
        '{ACT_ALLOC, 11'd5,    32'h0000_0000, 1'b0, 32'h0, STATUS_OK},
        '{ACT_FREE,  11'd3,    32'h0000_0000, 1'b0, 32'h0, STATUS_OK},
        '{ACT_ALLOC, 11'd2,    32'h0000_0000, 1'b0, 32'h0, STATUS_OK},
        '{ACT_ALLOC, 11'd4,    32'h0000_0000, 1'b0, 32'h0, STATUS_OK},
        '{ACT_ALLOC, 11'd1000, 32'h0000_0000, 1'b0, 32'h0, STATUS_OK},
        '{ACT_ALLOC, 11'd32,   32'h0000_0000, 1'b0, 32'h0, STATUS_OK},
        '{ACT_FREE,  11'd1024, 32'h0000_0000, 1'b0, 32'h0, STATUS_OK}
    };

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    bpra_req_if req_ch ();
    bpra_rsp_if rsp_ch ();

    bitmap_page_run_allocator #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bit                page_used [NUM_PAGES];
    logic [ADDR_W-1:0] base_reg;
    run_result_t       awaited_results [$];
    live_run_t         live_runs [$];

    bit src_idle_en;
    bit snk_idle_en;
    bit hold_req;

    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned n_alloc_items;
    int unsigned n_free_items;
    int unsigned n_ok;
    int unsigned n_nospace;
    int unsigned n_bad;
    int unsigned n_base_settings;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic run_result_t page_map_outcome(input action_t act,
                                                     input logic [CNT_W-1:0] cnt,
                                                     input logic [ADDR_W-1:0] addr);
        run_result_t       res;
        int unsigned       run;
        int unsigned       first;
        bit                found;
        logic [ADDR_W-1:0] off;
        longint unsigned   idx;

        res.address_res = '0;
        res.status      = STATUS_OK;
        run             = 0;
        first           = 0;
        found           = 1'b0;
        if (cnt == 0 || cnt > NUM_PAGES)
        begin
            res.status = STATUS_BAD;
        end
        else if (act == ACT_ALLOC)
        begin
            for (int i = 0; i < NUM_PAGES && !found; i++)
            begin
                if (page_used[i])
                begin
                    run = 0;
                end
                else
                begin
                    run++;
                    if (run == cnt)
                    begin
                        found = 1'b1;
                        first = i + 1 - cnt;
                    end
                end
            end
            if (found)
            begin
                for (int j = 0; j < cnt; j++)
                begin
                    page_used[first + j] = 1'b1;
                end
                res.address_res = base_reg + ADDR_W'(first * PAGE_BYTES);
            end
            else
            begin
                res.status = STATUS_NOSPACE;
            end
        end
        else
        begin
            off = addr - base_reg;
            idx = off / PAGE_BYTES;
            if ((off % PAGE_BYTES) != 0 || idx + cnt > NUM_PAGES)
            begin
                res.status = STATUS_BAD;
            end
            else
            begin
                for (int j = 0; j < cnt; j++)
                begin
                    page_used[idx + j] = 1'b0;
                end
            end
        end
        return res;
    endfunction

    task automatic offer_request(input action_t act, input logic [CNT_W-1:0] cnt,
                                 input logic [ADDR_W-1:0] addr, input logic typed,
                                 input run_result_t typed_res);
        run_result_t predicted;
        live_run_t   granted;
        int unsigned gap;

        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.page_count <= cnt;
        req_ch.address    <= addr;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);

        predicted = page_map_outcome(act, cnt, addr);
        awaited_results.push_back(typed ? typed_res : predicted);
        if (act == ACT_ALLOC)
        begin
            n_alloc_items++;
            if (predicted.status == STATUS_OK)
            begin
                granted.first = (predicted.address_res - base_reg) / PAGE_BYTES;
                granted.len   = cnt;
                live_runs.push_back(granted);
            end
        end
        else
        begin
            n_free_items++;
        end

        gap = 0;
        if (src_idle_en && $urandom_range(0, 99) < 25)
        begin
            gap = $urandom_range(1, 14);
        end
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic pick_random_request(output action_t act, output logic [CNT_W-1:0] cnt,
                                       output logic [ADDR_W-1:0] addr);
        int unsigned roll;
        int unsigned k;
        int unsigned n;
        int unsigned idx;
        int unsigned alloc_share;

        roll        = $urandom_range(0, 99);
        alloc_share = (live_runs.size() < 40) ? 55 : 30;
        addr        = $urandom();
        if (roll < alloc_share)
        begin
            act  = ACT_ALLOC;
            roll = $urandom_range(0, 99);
            if (roll < 70)
                cnt = CNT_W'($urandom_range(1, 16));
            else if (roll < 90)
                cnt = CNT_W'($urandom_range(17, 128));
            else if (roll < 97)
                cnt = CNT_W'($urandom_range(129, NUM_PAGES));
            else if (roll < 98)
                cnt = '0;
            else
                cnt = CNT_W'($urandom_range(NUM_PAGES, 2047));
        end
        else if (roll < 87 && live_runs.size() != 0)
        begin
            act = ACT_FREE;
            k   = $urandom_range(0, live_runs.size() - 1);
            n   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, live_runs[k].len)
                                              : live_runs[k].len;
            cnt  = CNT_W'(n);
            addr = base_reg + ADDR_W'(live_runs[k].first * PAGE_BYTES);
            if (n == live_runs[k].len)
            begin
                live_runs.delete(k);
            end
            else
            begin
                live_runs[k].first += n;
                live_runs[k].len   -= n;
            end
        end
        else
        begin
            act = ACT_FREE;
            idx = $urandom_range(0, NUM_PAGES - 1);
            case ($urandom_range(0, 3))
                0:
                begin
                    cnt = CNT_W'($urandom_range(0, 2047));
                end
                1:
                begin
                    cnt  = CNT_W'($urandom_range(1, NUM_PAGES - idx + 2));
                    addr = base_reg + ADDR_W'(idx * PAGE_BYTES);
                end
                2:
                begin
                    cnt  = CNT_W'($urandom_range(1, 8));
                    addr = base_reg - ADDR_W'($urandom_range(1, 64) * PAGE_BYTES);
                end
                default:
                begin
                    cnt  = CNT_W'($urandom_range(1, 8));
                    addr = base_reg + ADDR_W'(idx * PAGE_BYTES)
                         + ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
                end
            endcase
        end
    endtask

    task automatic write_base_address(input logic [ADDR_W-1:0] value);
        logic [PDATA_W-1:0] readback;

        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BASE_ADDR_OFFSET;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        base_reg = value;
        n_base_settings++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== value)
        begin
            $error("base_address mismatch: expected %h, actual %h", value, readback);
            error_count++;
        end
    endtask

    task automatic drain_results();
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        run_result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected item: address_res %h status %0d",
                       rsp_ch.address_res, rsp_ch.status);
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                case (want.status)
                    STATUS_OK:      n_ok++;
                    STATUS_NOSPACE: n_nospace++;
                    default:        n_bad++;
                endcase
                if (rsp_ch.address_res !== want.address_res)
                begin
                    $error("address_res mismatch: expected %h, actual %h",
                           want.address_res, rsp_ch.address_res);
                    error_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, rsp_ch.status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int unsigned burst;
        logic        lvl;

        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                lvl      = 1'b0;
                burst    = HOLD_CYCLES;
            end
            else if (snk_idle_en && $urandom_range(0, 99) < 30)
            begin
                lvl   = 1'b0;
                burst = $urandom_range(1, 14);
            end
            else
            begin
                lvl   = 1'b1;
                burst = $urandom_range(1, 20);
            end
            repeat (burst)
            begin
                @(posedge clk);
                rsp_ch.ready <= lvl;
            end
        end
    end

    initial
    begin
        logic [ADDR_W-1:0] phase_bases [NUM_PHASES];
        action_t           act;
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] addr;
        run_result_t       typed_res;

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_ALLOC;
        req_ch.page_count = '0;
        req_ch.address    = '0;
        base_reg          = '0;
        src_idle_en       = 1'b1;
        snk_idle_en       = 1'b1;
        hold_req          = 1'b0;
        error_count       = 0;
        cycle_count       = 0;
        n_alloc_items     = 0;
        n_free_items      = 0;
        n_ok              = 0;
        n_nospace         = 0;
        n_bad             = 0;
        n_base_settings   = 0;
        foreach (page_used[i])
            page_used[i] = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        write_base_address('0);
        foreach (request_rows[r])
        begin
            typed_res.address_res = request_rows[r].want_addr;
            typed_res.status      = request_rows[r].want_status;
            offer_request(request_rows[r].act, request_rows[r].cnt, request_rows[r].addr,
                          request_rows[r].typed, typed_res);
        end
        req_ch.valid <= 1'b0;
        drain_results();
        live_runs.delete();

        phase_bases[0] = 32'hFFFF_F000;
        phase_bases[1] = ADDR_W'($urandom_range(0, 32'hFFFFF)) << 12;
        phase_bases[2] = 32'h1234_5678;
        phase_bases[3] = ADDR_W'($urandom_range(0, 32'hFFFF_F000));
        phase_bases[4] = 32'h0000_0000;
        phase_bases[5] = 32'h8000_0000;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_base_address(phase_bases[p]);
            src_idle_en = (p != 0) && (p != NUM_PHASES - 1);
            snk_idle_en = (p != NUM_PHASES - 1);
            if (p == 0)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick_random_request(act, cnt, addr);
                offer_request(act, cnt, addr, 1'b0, typed_res);
            end
            req_ch.valid <= 1'b0;
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests (%0d allocate, %0d free) under %0d base settings",
                 n_alloc_items + n_free_items, n_alloc_items, n_free_items, n_base_settings);
        $display("Responses: %0d granted or freed, %0d out of space, %0d rejected",
                 n_ok, n_nospace, n_bad);
        if (error_count == 0 && awaited_results.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/bpra_pkg.sv
rtl/core/bpra_req_if.sv
rtl/core/bpra_rsp_if.sv
rtl/core/bpra_datapath.sv
rtl/core/bpra_ctrl.sv
rtl/core/bitmap_page_run_allocator.sv
tb/sv/tb_bitmap_page_run_allocator.sv
